// ----- hdl/pwmps_pkg.sv -----
// ----------------------------------------------------------------------------
// PWM period and duty setup: shared package
// Field widths, payload structs, operation and status codes, and the command
// and status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pwmps_pkg;

    localparam int UNITS_DEF         = 3;
    localparam int CHANNELS_DEF      = 4;
    localparam int BASE_CLOCK_DEF    = 16000000;

    localparam int DIV_DW            = 31;
    localparam int DIV_VW            = 25;

    localparam logic [4:0]  RES_RESET       = 5'd8;
    localparam logic [4:0]  RES_MIN         = 5'd1;
    localparam logic [4:0]  RES_MAX         = 5'd16;
    localparam logic [23:0] DEFAULT_FREQ_HZ = 24'd500;
    localparam logic [23:0] BAND_TOP        = 24'd512;
    localparam logic [23:0] FREQ_FLOOR      = 24'd4;
    localparam logic [15:0] INVERT_FLAG     = 16'h8000;

    typedef enum logic [1:0] {
        ACT_SET_FREQ   = 2'd0,
        ACT_WRITE_DUTY = 2'd1,
        ACT_RELEASE    = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_BAD_UNIT   = 2'd1,
        ST_NO_CHANNEL = 2'd2,
        ST_UNCHANGED  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        DIV_MAX  = 2'd0,
        DIV_TOP  = 2'd1,
        DIV_DUTY = 2'd2
    } t_div_sel;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  unit_index;
        logic [23:0] frequency_hz;
        logic [5:0]  pin_number;
        logic [15:0] duty_value;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  prescale_shift;
        logic [14:0] top_count;
        logic [23:0] applied_frequency;
        logic [1:0]  channel_slot;
        logic [15:0] compare_word;
    } t_result;

    typedef struct packed {
        logic     load;
        logic     load_req;
        logic     load_default;
        logic     clear_unit;
        logic     band;
        logic     commit;
        logic     mul;
        logic     claim;
        logic     finish;
        logic     status_we;
        t_status  status_code;
        logic     div_start;
        t_div_sel div_sel;
    } t_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       act_known;
        logic       unit_bad;
        logic       freq_same;
        logic       freq_unset;
        logic       req_high;
        logic       found;
        logic       div_done;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- hdl/pwmps_div.sv -----
// ----------------------------------------------------------------------------
// PWM period and duty setup: shared divider
// Restoring radix-2 divider, one quotient bit per cycle. The quotient stays
// on its output after the done pulse until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module pwmps_div import pwmps_pkg::*; #(
    parameter int DW = DIV_DW,
    parameter int VW = DIV_VW
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [VW-1:0] i_divisor,
    output logic      [DW-1:0] o_quotient,
    output logic               o_done
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [DW-1:0] r_quo, n_quo;
    logic [VW:0]   r_rem, n_rem;
    logic [VW-1:0] r_dvs, n_dvs;
    logic [VW:0]   rem_sh;
    logic          ge;

    always_comb begin
        rem_sh = {r_rem[VW-1:0], r_quo[DW-1]};
        ge     = rem_sh >= {1'b0, r_dvs};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(DW);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
            n_quo = {r_quo[DW-2:0], ge};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

`default_nettype wire

// ----- hdl/pwmps_dp.sv -----
// ----------------------------------------------------------------------------
// PWM period and duty setup: datapath
// Holds the unit and slot registers, the item being worked on, the resolution
// register and the result register, and carries out the controller's commands.
// ----------------------------------------------------------------------------
`default_nettype none

module pwmps_dp import pwmps_pkg::*; #(
    parameter int UNITS             = UNITS_DEF,
    parameter int CHANNELS_PER_UNIT = CHANNELS_DEF,
    parameter int BASE_CLOCK_HZ     = BASE_CLOCK_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_item      i_item,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [4:0] i_cfg_data,
    input  wire t_cmd       i_cmd,
    output t_dp_status      o_status,
    output logic            o_result_valid,
    output t_result         o_result
);

    localparam int UIW = (UNITS > 1) ? $clog2(UNITS) : 1;
    localparam int CIW = (CHANNELS_PER_UNIT > 1) ? $clog2(CHANNELS_PER_UNIT) : 1;

    logic [23:0] r_freq [UNITS];
    logic [2:0]  r_pre  [UNITS];
    logic [14:0] r_top  [UNITS];
    logic        r_used [UNITS][CHANNELS_PER_UNIT];
    logic [5:0]  r_pin  [UNITS][CHANNELS_PER_UNIT];

    t_item       r_item;
    logic [4:0]  r_res;
    logic [23:0] r_f;
    logic [2:0]  r_p;
    logic [30:0] r_prod;
    logic        r_found;
    logic [CIW-1:0] r_slot;
    logic        r_claimed;
    logic [15:0] r_cmp;
    t_status     r_stat;
    logic        r_valid;
    t_result     r_result;
    t_result     n_result;

    logic [UIW-1:0]    u;
    logic [23:0]       cur_freq;
    logic [2:0]        cur_pre;
    logic [14:0]       cur_top;
    logic [4:0]        res_eff;
    logic [15:0]       fs;
    logic [23:0]       band_f;
    logic [2:0]        band_p;
    logic [DIV_VW-1:0] top_dvs;
    logic [DIV_DW-1:0] div_dividend;
    logic [DIV_VW-1:0] div_divisor;
    logic [DIV_DW-1:0] quo;
    logic              div_done;
    logic [30:0]       prod_w;
    logic              hit_found;
    logic [CIW-1:0]    hit_idx;
    logic [14:0]       duty_cl;
    logic              act_known;
    logic              unit_bad;

    assign u         = r_item.unit_index[UIW-1:0];
    assign unit_bad  = {1'b0, r_item.unit_index} >= 3'(UNITS);
    assign act_known = (r_item.action == ACT_SET_FREQ) || (r_item.action == ACT_WRITE_DUTY) ||
                       (r_item.action == ACT_RELEASE);
    assign cur_freq  = r_freq[u];
    assign cur_pre   = r_pre[u];
    assign cur_top   = r_top[u];

    assign res_eff = (r_res < RES_MIN) ? RES_MIN : ((r_res > RES_MAX) ? RES_MAX : r_res);
    assign fs      = 16'((17'd1 << res_eff) - 17'd1);

    always_comb begin
        band_f = r_f;
        band_p = 3'd7;
        priority if (r_f > BAND_TOP) begin
            band_p = 3'd0;
            band_f = (r_f > quo[23:0]) ? quo[23:0] : r_f;
        end else if (r_f > (BAND_TOP >> 1)) begin
            band_p = 3'd1;
        end else if (r_f > (BAND_TOP >> 2)) begin
            band_p = 3'd2;
        end else if (r_f > (BAND_TOP >> 3)) begin
            band_p = 3'd3;
        end else if (r_f > (BAND_TOP >> 4)) begin
            band_p = 3'd4;
        end else if (r_f > (BAND_TOP >> 5)) begin
            band_p = 3'd5;
        end else if (r_f > (BAND_TOP >> 6)) begin
            band_p = 3'd6;
        end else begin
            band_p = 3'd7;
            band_f = (r_f < FREQ_FLOOR) ? FREQ_FLOOR : r_f;
        end
    end

    assign top_dvs = DIV_VW'(band_f) << band_p;

    always_comb begin
        unique case (i_cmd.div_sel)
            DIV_MAX: begin
                div_dividend = DIV_DW'(BASE_CLOCK_HZ);
                div_divisor  = DIV_VW'(fs);
            end
            DIV_TOP: begin
                div_dividend = DIV_DW'(BASE_CLOCK_HZ);
                div_divisor  = top_dvs;
            end
            DIV_DUTY: begin
                div_dividend = r_prod;
                div_divisor  = DIV_VW'(fs);
            end
            default: begin
                div_dividend = DIV_DW'(BASE_CLOCK_HZ);
                div_divisor  = DIV_VW'(fs);
            end
        endcase
    end

    pwmps_div #(
        .DW (DIV_DW),
        .VW (DIV_VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (quo),
        .o_done     (div_done)
    );

    assign prod_w = 31'(cur_top) * 31'(r_item.duty_value);

    always_comb begin
        hit_found = 1'b0;
        hit_idx   = '0;
        for (int c = CHANNELS_PER_UNIT - 1; c >= 0; c--) begin
            if (!r_used[u][c] || (r_pin[u][c] == r_item.pin_number)) begin
                hit_found = 1'b1;
                hit_idx   = CIW'(c);
            end
        end
    end

    assign duty_cl = (quo > DIV_DW'(cur_top)) ? cur_top : quo[14:0];

    always_comb begin
        n_result        = '0;
        n_result.status = r_stat;
        if (act_known && !unit_bad) begin
            n_result.prescale_shift    = cur_pre;
            n_result.top_count         = cur_top;
            n_result.applied_frequency = cur_freq;
            n_result.channel_slot      = r_claimed ? 2'(r_slot) : 2'd0;
            n_result.compare_word      = r_cmp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < UNITS; i++) begin
                r_freq[i] <= '0;
                r_pre[i]  <= '0;
                r_top[i]  <= '0;
                for (int c = 0; c < CHANNELS_PER_UNIT; c++) begin
                    r_used[i][c] <= 1'b0;
                end
            end
        end else begin
            if (i_cmd.clear_unit) begin
                r_freq[u] <= '0;
                r_top[u]  <= '0;
            end
            if (i_cmd.commit) begin
                r_freq[u] <= r_f;
                r_pre[u]  <= r_p;
                r_top[u]  <= quo[14:0];
            end
            if (i_cmd.claim) begin
                r_used[u][r_slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.claim) begin
            r_pin[u][r_slot] <= r_item.pin_number;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res     <= RES_RESET;
            r_valid   <= 1'b0;
            r_claimed <= 1'b0;
            r_stat    <= ST_DONE;
        end else begin
            if (i_cfg_valid) begin
                r_res <= i_cfg_data;
            end
            r_valid <= i_cmd.finish;
            if (i_cmd.load) begin
                r_claimed <= 1'b0;
                r_stat    <= ST_DONE;
            end
            if (i_cmd.claim) begin
                r_claimed <= 1'b1;
            end
            if (i_cmd.status_we) begin
                r_stat <= i_cmd.status_code;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
            r_cmp  <= '0;
        end
        if (i_cmd.load_req) begin
            r_f <= r_item.frequency_hz;
        end
        if (i_cmd.load_default) begin
            r_f <= DEFAULT_FREQ_HZ;
        end
        if (i_cmd.band) begin
            r_f <= band_f;
            r_p <= band_p;
        end
        if (i_cmd.mul) begin
            r_prod  <= prod_w;
            r_found <= hit_found;
            r_slot  <= hit_idx;
        end
        if (i_cmd.claim) begin
            r_cmp <= INVERT_FLAG | {1'b0, duty_cl};
        end
        if (i_cmd.finish) begin
            r_result <= n_result;
        end
    end

    always_comb begin
        o_status            = '0;
        o_status.action     = r_item.action;
        o_status.act_known  = act_known;
        o_status.unit_bad   = unit_bad;
        o_status.freq_same  = r_item.frequency_hz == cur_freq;
        o_status.freq_unset = cur_freq == '0;
        o_status.req_high   = r_item.frequency_hz > BAND_TOP;
        o_status.found      = r_found;
        o_status.div_done   = div_done;
    end

    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = r_valid;
    assign o_result       = r_result;

endmodule

`default_nettype wire

// ----- hdl/pwmps_ctrl.sv -----
// ----------------------------------------------------------------------------
// PWM period and duty setup: controller
// Sequences one item at a time through decode, the divisions, the duty
// product, the slot claim and the result, by commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module pwmps_ctrl import pwmps_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire t_dp_status i_status,
    output t_cmd            o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_DECODE  = 9'b000000010,
        S_MAXDIV  = 9'b000000100,
        S_BAND    = 9'b000001000,
        S_TOPDIV  = 9'b000010000,
        S_MUL     = 9'b000100000,
        S_SLOT    = 9'b001000000,
        S_DUTYDIV = 9'b010000000,
        S_DONE    = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (!i_status.act_known) begin
                    n_state = S_DONE;
                end else if (i_status.unit_bad) begin
                    o_cmd.status_we   = 1'b1;
                    o_cmd.status_code = ST_BAD_UNIT;
                    n_state           = S_DONE;
                end else if (i_status.action == ACT_SET_FREQ) begin
                    if (i_status.freq_same) begin
                        o_cmd.status_we   = 1'b1;
                        o_cmd.status_code = ST_UNCHANGED;
                        n_state           = S_DONE;
                    end else begin
                        o_cmd.load_req = 1'b1;
                        if (i_status.req_high) begin
                            o_cmd.div_start = 1'b1;
                            o_cmd.div_sel   = DIV_MAX;
                            n_state         = S_MAXDIV;
                        end else begin
                            n_state = S_BAND;
                        end
                    end
                end else if (i_status.action == ACT_WRITE_DUTY) begin
                    if (i_status.freq_unset) begin
                        o_cmd.load_default = 1'b1;
                        n_state            = S_BAND;
                    end else begin
                        n_state = S_MUL;
                    end
                end else begin
                    o_cmd.clear_unit = 1'b1;
                    n_state          = S_DONE;
                end
            end
            S_MAXDIV: begin
                if (i_status.div_done) begin
                    n_state = S_BAND;
                end
            end
            S_BAND: begin
                o_cmd.band      = 1'b1;
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_TOP;
                n_state         = S_TOPDIV;
            end
            S_TOPDIV: begin
                if (i_status.div_done) begin
                    o_cmd.commit = 1'b1;
                    n_state = (i_status.action == ACT_WRITE_DUTY) ? S_MUL : S_DONE;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SLOT;
            end
            S_SLOT: begin
                if (i_status.found) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_DUTY;
                    n_state         = S_DUTYDIV;
                end else begin
                    o_cmd.status_we   = 1'b1;
                    o_cmd.status_code = ST_NO_CHANNEL;
                    n_state           = S_DONE;
                end
            end
            S_DUTYDIV: begin
                if (i_status.div_done) begin
                    o_cmd.claim = 1'b1;
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = r_state != S_IDLE;

    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_DECODE))
        else $error("Accepted beat did not move the controller to decode.");

    a_done_in_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.div_done |-> ((r_state == S_MAXDIV) || (r_state == S_TOPDIV) ||
                               (r_state == S_DUTYDIV)))
        else $error("Divider finished outside a division wait state.");

    a_idle_no_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !o_cmd.div_start)
        else $error("Division started while the controller was idle.");

    a_finish_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> (!busy && !o_cmd.finish))
        else $error("Result was not followed by a return to idle.");

endmodule

`default_nettype wire

// ----- hdl/pwm_period_and_duty_setup_core.sv -----
// ----------------------------------------------------------------------------
// PWM period and duty setup core
// Sets prescaler, counter top and frequency of the PWM units and scales duty
// values into compare words for the units' channel slots.
//
//   Channel   Signals                          Beat taken when
//   item      start, busy, i_item              start high and busy low
//   result    o_result_valid, o_result         o_result_valid high
//   config    i_cfg_valid, o_cfg_ready,        i_cfg_valid and o_cfg_ready
//             i_cfg_data
//
// One item at a time; the next item can be taken at the same edge as the
// result of the last. Release, a bad unit, an unused action and an unchanged
// frequency go from decode straight to the result and use no division. Each
// division uses the shared divider; two are needed above the top band or when
// a duty write must first set the default frequency, otherwise at most one.
// A synchronous reset clears all units and slots; results cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_period_and_duty_setup_core import pwmps_pkg::*; #(
    parameter int UNITS             = UNITS_DEF,
    parameter int CHANNELS_PER_UNIT = CHANNELS_DEF,
    parameter int BASE_CLOCK_HZ     = BASE_CLOCK_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire t_item      i_item,
    output logic            o_result_valid,
    output t_result         o_result,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [4:0] i_cfg_data
);

    t_cmd       cmd;
    t_dp_status dp_status;

    pwmps_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (dp_status),
        .o_cmd    (cmd)
    );

    pwmps_dp #(
        .UNITS             (UNITS),
        .CHANNELS_PER_UNIT (CHANNELS_PER_UNIT),
        .BASE_CLOCK_HZ     (BASE_CLOCK_HZ)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (cmd),
        .o_status       (dp_status),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

`default_nettype wire

// ----- tb/pwm_period_and_duty_setup_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PWM period and duty setup core: self-checking testbench
// A short table of directed commands is followed by random phases, each run
// after a new duty resolution is written. Every accepted command is passed
// through a behavioural copy of the units and channel slots; each result beat
// is compared field by field with the oldest outstanding expected result.
// ----------------------------------------------------------------------------

module pwm_period_and_duty_setup_core_test;

    import pwmps_pkg::*;

    localparam logic [1:0] ACT_UNUSED     = 2'd3;
    localparam int         SLOTS          = UNITS_DEF * CHANNELS_DEF;
    localparam int         PHASE_ITEMS    = 180;
    localparam int         WATCHDOG_LIMIT = 2000;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          start       = 1'b0;
    logic          busy;
    t_item         i_item      = '0;
    logic          o_result_valid;
    t_result       o_result;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [4:0]    i_cfg_data  = '0;

    logic [23:0]   unit_freq  [UNITS_DEF] = '{default: '0};
    logic [2:0]    unit_shift [UNITS_DEF] = '{default: '0};
    logic [14:0]   unit_top   [UNITS_DEF] = '{default: '0};
    bit            slot_taken [SLOTS]     = '{default: 1'b0};
    logic [5:0]    slot_pin   [SLOTS]     = '{default: '0};
    logic [4:0]    duty_bits              = RES_RESET;

    t_result       expected_results [$];
    int            mismatches  = 0;
    int            idle_cycles = 0;
    bit            allow_idle  = 1'b1;
    bit            idle_on     = 1'b1;

    t_item         table_items [$];
    bit            table_typed [$];
    t_result       table_want  [$];

    pwm_period_and_duty_setup_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int full_scale(logic [4:0] bits);
        int r;
        r = bits;
        if (r < RES_MIN) r = RES_MIN;
        if (r > RES_MAX) r = RES_MAX;
        return (1 << r) - 1;
    endfunction

    function automatic bit program_unit(int u, logic [23:0] req);
        logic [31:0] f;
        logic [2:0]  p;
        if (req == unit_freq[u]) return 1'b0;
        f = req;
        if (f > BAND_TOP) begin
            if (f > 32'(BASE_CLOCK_DEF / full_scale(duty_bits))) begin
                f = 32'(BASE_CLOCK_DEF / full_scale(duty_bits));
            end
            p = 3'd0;
        end else if (f > 256) begin
            p = 3'd1;
        end else if (f > 128) begin
            p = 3'd2;
        end else if (f > 64) begin
            p = 3'd3;
        end else if (f > 32) begin
            p = 3'd4;
        end else if (f > 16) begin
            p = 3'd5;
        end else if (f > 8) begin
            p = 3'd6;
        end else begin
            if (f < FREQ_FLOOR) f = FREQ_FLOOR;
            p = 3'd7;
        end
        unit_shift[u] = p;
        unit_top[u]   = 15'(32'(BASE_CLOCK_DEF) / (f << p));
        unit_freq[u]  = f[23:0];
        return 1'b1;
    endfunction

    function automatic t_result predict_setup(t_item it);
        t_result     r;
        int          u;
        int          s;
        bit          placed;
        logic [31:0] scaled;
        r = '0;
        if (it.action == ACT_UNUSED) return r;
        if (it.unit_index >= UNITS_DEF) begin
            r.status = ST_BAD_UNIT;
            return r;
        end
        u = it.unit_index;
        case (t_action'(it.action))
            ACT_SET_FREQ: begin
                if (!program_unit(u, it.frequency_hz)) r.status = ST_UNCHANGED;
            end
            ACT_WRITE_DUTY: begin
                if (unit_freq[u] == '0) void'(program_unit(u, DEFAULT_FREQ_HZ));
                placed = 1'b0;
                for (int c = 0; c < CHANNELS_DEF && !placed; c++) begin
                    s = u * CHANNELS_DEF + c;
                    if (!slot_taken[s] || slot_pin[s] == it.pin_number) begin
                        scaled = (32'(unit_top[u]) * 32'(it.duty_value))
                                 / 32'(full_scale(duty_bits));
                        if (scaled > 32'(unit_top[u])) scaled = 32'(unit_top[u]);
                        slot_taken[s]  = 1'b1;
                        slot_pin[s]    = it.pin_number;
                        r.channel_slot = 2'(c);
                        r.compare_word = scaled[15:0] | INVERT_FLAG;
                        placed = 1'b1;
                    end
                end
                if (!placed) r.status = ST_NO_CHANNEL;
            end
            default: begin
                unit_freq[u] = '0;
                unit_top[u]  = '0;
            end
        endcase
        r.prescale_shift    = unit_shift[u];
        r.top_count         = unit_top[u];
        r.applied_frequency = unit_freq[u];
        return r;
    endfunction

    function automatic t_item cmd(logic [1:0] a, logic [1:0] u, logic [23:0] f,
                                  logic [5:0] p, logic [15:0] d);
        t_item it;
        it.action       = a;
        it.unit_index   = u;
        it.frequency_hz = f;
        it.pin_number   = p;
        it.duty_value   = d;
        return it;
    endfunction

    function automatic t_result outcome(t_status st, logic [2:0] sh, logic [14:0] top,
                                        logic [23:0] f, logic [1:0] slot,
                                        logic [15:0] word);
        t_result r;
        r.status            = st;
        r.prescale_shift    = sh;
        r.top_count         = top;
        r.applied_frequency = f;
        r.channel_slot      = slot;
        r.compare_word      = word;
        return r;
    endfunction

    task automatic add_row(t_item it, bit typed, t_result want);
        table_items.push_back(it);
        table_typed.push_back(typed);
        table_want.push_back(want);
    endtask

    task automatic note_mismatch(string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic send_command(t_item it, bit typed, t_result want);
        int      gap;
        t_result predicted;
        gap = 0;
        if (allow_idle) begin
            if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
            if (idle_on && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 8);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        predicted = predict_setup(it);
        expected_results.push_back(typed ? want : predicted);
    endtask

    task automatic write_resolution(logic [4:0] bits);
        do @(posedge i_clk); while (expected_results.size() != 0 || busy);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= bits;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        duty_bits = bits;
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_result_valid) begin
            got = o_result;
            if (expected_results.size() == 0) begin
                note_mismatch("result beat with no command outstanding");
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                    note_mismatch($sformatf("status %0d, expected %0d",
                                            got.status, want.status));
                if (got.prescale_shift !== want.prescale_shift)
                    note_mismatch($sformatf("prescale_shift %0d, expected %0d",
                                            got.prescale_shift, want.prescale_shift));
                if (got.top_count !== want.top_count)
                    note_mismatch($sformatf("top_count %0d, expected %0d",
                                            got.top_count, want.top_count));
                if (got.applied_frequency !== want.applied_frequency)
                    note_mismatch($sformatf("applied_frequency %0d, expected %0d",
                                            got.applied_frequency, want.applied_frequency));
                if (got.channel_slot !== want.channel_slot)
                    note_mismatch($sformatf("channel_slot %0d, expected %0d",
                                            got.channel_slot, want.channel_slot));
                if (got.compare_word !== want.compare_word)
                    note_mismatch($sformatf("compare_word %h, expected %h",
                                            got.compare_word, want.compare_word));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [4:0] resolutions [7];
        t_item      it;
        int         u;
        int         s;
        int         pick;
        int         fs;

        add_row(cmd(ACT_SET_FREQ, 2'd0, 24'd0, 6'd0, 16'd0), 1'b1,
                outcome(ST_UNCHANGED, 3'd0, 15'd0, 24'd0, 2'd0, 16'd0));
        add_row(cmd(ACT_SET_FREQ, 2'(UNITS_DEF), 24'hFFFFFF, 6'h3F, 16'hFFFF), 1'b1,
                outcome(ST_BAD_UNIT, 3'd0, 15'd0, 24'd0, 2'd0, 16'd0));
        add_row(cmd(ACT_UNUSED, 2'(UNITS_DEF), 24'hFFFFFF, 6'h3F, 16'hFFFF), 1'b1,
                outcome(ST_DONE, 3'd0, 15'd0, 24'd0, 2'd0, 16'd0));
        add_row(cmd(ACT_RELEASE, 2'd1, 24'd0, 6'd0, 16'd0), 1'b1,
                outcome(ST_DONE, 3'd0, 15'd0, 24'd0, 2'd0, 16'd0));
        add_row(cmd(ACT_SET_FREQ, 2'd0, 24'hFFFFFF, 6'd0, 16'd0), 1'b0, '0);
        add_row(cmd(ACT_SET_FREQ, 2'd0, 24'hFFFFFF, 6'd0, 16'd0), 1'b0, '0);
        add_row(cmd(ACT_SET_FREQ, 2'd0, 24'd62745, 6'd0, 16'd0), 1'b1,
                outcome(ST_UNCHANGED, 3'd0, 15'd255, 24'd62745, 2'd0, 16'd0));
        add_row(cmd(ACT_SET_FREQ, 2'd1, 24'd513, 6'd0, 16'd0), 1'b0, '0);
        add_row(cmd(ACT_SET_FREQ, 2'd1, 24'd512, 6'd0, 16'd0), 1'b0, '0);
        add_row(cmd(ACT_SET_FREQ, 2'd1, 24'd257, 6'd0, 16'd0), 1'b0, '0);
        add_row(cmd(ACT_SET_FREQ, 2'd1, 24'd256, 6'd0, 16'd0), 1'b0, '0);
        add_row(cmd(ACT_SET_FREQ, 2'd1, 24'd129, 6'd0, 16'd0), 1'b0, '0);
        add_row(cmd(ACT_SET_FREQ, 2'd1, 24'd33, 6'd0, 16'd0), 1'b0, '0);
        add_row(cmd(ACT_SET_FREQ, 2'd1, 24'd9, 6'd0, 16'd0), 1'b0, '0);
        add_row(cmd(ACT_SET_FREQ, 2'd1, 24'd8, 6'd0, 16'd0), 1'b0, '0);
        add_row(cmd(ACT_SET_FREQ, 2'd1, 24'd3, 6'd0, 16'd0), 1'b0, '0);
        add_row(cmd(ACT_SET_FREQ, 2'd1, 24'd0, 6'd0, 16'd0), 1'b0, '0);
        add_row(cmd(ACT_WRITE_DUTY, 2'd2, 24'd0, 6'h3F, 16'hFFFF), 1'b1,
                outcome(ST_DONE, 3'd1, 15'd16000, 24'd500, 2'd0, 16'hBE80));
        add_row(cmd(ACT_WRITE_DUTY, 2'd2, 24'd0, 6'd0, 16'd0), 1'b1,
                outcome(ST_DONE, 3'd1, 15'd16000, 24'd500, 2'd1, 16'h8000));
        add_row(cmd(ACT_WRITE_DUTY, 2'd2, 24'd0, 6'h3F, 16'd128), 1'b0, '0);
        add_row(cmd(ACT_WRITE_DUTY, 2'd2, 24'd0, 6'd5, 16'd255), 1'b0, '0);
        add_row(cmd(ACT_WRITE_DUTY, 2'd2, 24'd0, 6'd6, 16'd1), 1'b0, '0);
        add_row(cmd(ACT_WRITE_DUTY, 2'd2, 24'd0, 6'd7, 16'd9), 1'b1,
                outcome(ST_NO_CHANNEL, 3'd1, 15'd16000, 24'd500, 2'd0, 16'd0));
        add_row(cmd(ACT_RELEASE, 2'd2, 24'd0, 6'd0, 16'd0), 1'b1,
                outcome(ST_DONE, 3'd1, 15'd0, 24'd0, 2'd0, 16'd0));
        add_row(cmd(ACT_WRITE_DUTY, 2'd2, 24'd0, 6'd9, 16'd100), 1'b1,
                outcome(ST_NO_CHANNEL, 3'd1, 15'd16000, 24'd500, 2'd0, 16'd0));

        resolutions = '{5'd0, RES_MAX, 5'h1F, RES_MIN, 5'($urandom_range(2, 15)),
                        5'($urandom_range(17, 30)), RES_RESET};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < table_items.size(); r++) begin
            send_command(table_items[r], table_typed[r], table_want[r]);
        end
        start <= 1'b0;

        for (int ph = 0; ph < 7; ph++) begin
            write_resolution(resolutions[ph]);
            if (ph == 6) allow_idle = 1'b0;
            fs = full_scale(duty_bits);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 19);
                if (pick < 7) begin
                    it.action = ACT_SET_FREQ;
                end else if (pick < 16) begin
                    it.action = ACT_WRITE_DUTY;
                end else if (pick < 18) begin
                    it.action = ACT_RELEASE;
                end else begin
                    it.action = ACT_UNUSED;
                end
                u = ($urandom_range(0, 11) == 0) ? UNITS_DEF : $urandom_range(0, UNITS_DEF - 1);
                it.unit_index = 2'(u);

                case ($urandom_range(0, 9))
                    0:       it.frequency_hz = 24'($urandom_range(0, 8));
                    1:       it.frequency_hz = 24'((1 << $urandom_range(3, 9))
                                                   + $urandom_range(0, 1));
                    2, 3:    it.frequency_hz = 24'($urandom_range(9, 512));
                    4, 5:    it.frequency_hz = 24'($urandom_range(513, 70000));
                    6:       it.frequency_hz = 24'($urandom());
                    7, 8:    it.frequency_hz = unit_freq[u % UNITS_DEF];
                    default: it.frequency_hz = 24'(BASE_CLOCK_DEF / fs
                                                   + $urandom_range(0, 1));
                endcase

                s = (u % UNITS_DEF) * CHANNELS_DEF + $urandom_range(0, CHANNELS_DEF - 1);
                if ($urandom_range(0, 9) < 6 && slot_taken[s]) begin
                    it.pin_number = slot_pin[s];
                end else begin
                    it.pin_number = 6'($urandom_range(0, 63));
                end

                case ($urandom_range(0, 5))
                    0:       it.duty_value = 16'd0;
                    1:       it.duty_value = 16'(fs);
                    2:       it.duty_value = 16'(fs + 1);
                    3:       it.duty_value = 16'hFFFF;
                    4:       it.duty_value = 16'($urandom() & fs);
                    default: it.duty_value = 16'($urandom());
                endcase

                send_command(it, 1'b0, '0);
            end
            start <= 1'b0;
        end

        do @(posedge i_clk); while (expected_results.size() != 0);
        repeat (80) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
